[rtl/natural_log_by_range_reduction_macros.svh]
// Assertion macros shared by the natural log RTL.
`ifndef NATURAL_LOG_BY_RANGE_REDUCTION_MACROS_SVH
`define NATURAL_LOG_BY_RANGE_REDUCTION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NLRR_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NLRR_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

[rtl/lnrr_pkg.sv]
// Package: constants and pipeline types for the natural log datapath.
`default_nettype none
package lnrr_pkg;

  localparam int WORK_BITS = 30;
  localparam int IN_FRAC   = 16;
  localparam int X_W       = 32;
  localparam int MILLI_W   = 15;
  localparam int IN_W      = 17;
  localparam int OUT_W     = 21;

  localparam int N_PASS1 = 13;
  localparam int N_PASS2 = 12;
  localparam int N_PASS3 = 12;
  localparam int N_PASS4 = 12;

  localparam logic [63:0] NANO     = 64'd1000000000;
  localparam logic [63:0] HALF_NANO = 64'd500000000;
  localparam logic [63:0] TWO_62   = 64'h4000_0000_0000_0000;

  localparam logic [63:0] K_E1_64    = ((64'd2718281828 << WORK_BITS) + HALF_NANO) / NANO;
  localparam logic [63:0] K_E01_64   = ((64'd1105170918 << WORK_BITS) + HALF_NANO) / NANO;
  localparam logic [63:0] K_E001_64  = ((64'd1010050167 << WORK_BITS) + HALF_NANO) / NANO;
  localparam logic [63:0] K_E0001_64 = ((64'd1001000500 << WORK_BITS) + HALF_NANO) / NANO;
  localparam logic [63:0] R_E01_64   = TWO_62 / K_E01_64;
  localparam logic [63:0] R_E0001_64 = TWO_62 / K_E0001_64;

  localparam logic [X_W-1:0] ONE     = X_W'(64'd1 << WORK_BITS);
  localparam logic [X_W-1:0] K_E1    = K_E1_64[X_W-1:0];
  localparam logic [X_W-1:0] K_E01   = K_E01_64[X_W-1:0];
  localparam logic [X_W-1:0] K_E001  = K_E001_64[X_W-1:0];
  localparam logic [X_W-1:0] K_E0001 = K_E0001_64[X_W-1:0];
  localparam logic [X_W-1:0] R_E01   = R_E01_64[X_W-1:0];
  localparam logic [X_W-1:0] R_E0001 = R_E0001_64[X_W-1:0];

  localparam logic signed [MILLI_W-1:0] STEP_E1    = -15'sd1000;
  localparam logic signed [MILLI_W-1:0] STEP_E01   = 15'sd100;
  localparam logic signed [MILLI_W-1:0] STEP_E001  = -15'sd10;
  localparam logic signed [MILLI_W-1:0] STEP_E0001 = 15'sd1;

  // 2^30 = 1000 * BULK_INT + BULK_REM; floor(w/125) = (w * DIV125_M) >> DIV125_S
  localparam logic [20:0] BULK_INT = 21'd1073741;
  localparam logic [9:0]  BULK_REM = 10'd824;
  localparam logic [21:0] DIV125_M = 22'd2147484;
  localparam int          DIV125_S = 28;
  localparam logic [32:0] DIV3_M   = 33'h0_AAAA_AAAB;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [X_W-1:0]            x;
    logic signed [MILLI_W-1:0] milli;
  } stage_t;

  typedef struct packed {
    stage_t      s;
    logic        cond;
    logic [63:0] prod;
  } div_a_t;

  typedef struct packed {
    stage_t         s;
    logic           cond;
    logic [X_W-1:0] q;
    logic [32:0]    qk;
  } div_b_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic                 neg;
    logic [30:0]          d;
    logic [30:0]          d2;
    logic [30:0]          d3;
    logic [63:0]          t3;
    logic [34:0]          bulk_hi;
    logic [23:0]          v;
    logic [42:0]          tb;
    logic [34:0]          bulk;
    logic [32:0]          r;
    logic signed [36:0]   total;
  } tail_t;

endpackage
`default_nettype wire

[rtl/lnrr_mul_step.sv]
// One conditional multiply-by-constant reduction step (single register stage).
`default_nettype none
module lnrr_mul_step import lnrr_pkg::*; #(
  parameter logic [31:0]         K    = 32'd1,
  parameter logic signed [14:0]  STEP = 15'sd0
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire stage_t d_i,
  output stage_t      q_o
);

  stage_t      q_r, q_nxt;
  logic [63:0] prod;
  logic        cond;

  always_comb begin
    cond  = d_i.x < ONE;
    prod  = 64'(d_i.x) * 64'(K);
    q_nxt = d_i;
    if (cond) begin
      q_nxt.x     = prod[WORK_BITS +: X_W];
      q_nxt.milli = d_i.milli + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

[rtl/lnrr_div_step.sv]
// One conditional divide-by-constant reduction step (reciprocal, three stages).
`default_nettype none
module lnrr_div_step import lnrr_pkg::*; #(
  parameter logic [31:0]         K    = 32'd1,
  parameter logic [31:0]         R    = 32'd1,
  parameter logic signed [14:0]  STEP = 15'sd0
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire stage_t d_i,
  output stage_t      q_o
);

  div_a_t      a_r, a_nxt;
  div_b_t      b_r, b_nxt;
  stage_t      c_r, c_nxt;
  logic [63:0] qk_full;
  logic [32:0] rem;
  logic [X_W-1:0] q_fix;

  always_comb begin
    a_nxt.s    = d_i;
    a_nxt.cond = d_i.x > ONE;
    a_nxt.prod = 64'(d_i.x) * 64'(R);
  end

  always_comb begin
    b_nxt.s    = a_r.s;
    b_nxt.cond = a_r.cond;
    b_nxt.q    = a_r.prod[63:32];
    qk_full    = 64'(a_r.prod[63:32]) * 64'(K);
    b_nxt.qk   = qk_full[32:0];
  end

  always_comb begin
    rem   = {b_r.s.x[2:0], 30'd0} - b_r.qk;
    q_fix = (rem >= {1'b0, K}) ? b_r.q + 32'd1 : b_r.q;
    c_nxt = b_r.s;
    if (b_r.cond) begin
      c_nxt.x     = q_fix;
      c_nxt.milli = b_r.s.milli + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.s.valid <= 1'b0;
      b_r.s.valid <= 1'b0;
      c_r.valid   <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  assign q_o = c_r;

endmodule
`default_nettype wire

[rtl/natural_log_by_range_reduction.sv]
// Top level: pipelined natural log of a Q1.16 probability.
`default_nettype none
`include "natural_log_by_range_reduction_macros.svh"
// Takes one probability per cycle when not stalled and returns ln(p) with
// FRAC_BITS fraction bits, saturated to 21 bits signed; a zero input gives
// log 0 with the negative-infinity flag set. The pipeline has 13 multiply
// stages by e, 12 divide steps by e^0.1 (three stages each), 12 multiply
// stages by e^0.01, 12 divide steps by e^0.001, then 7 stages for the cubic
// series, offset scaling and output rounding. Each unused reduction step
// passes its item through unchanged. The whole pipeline advances together;
// when a result waits on out_ready, every stage holds.
module natural_log_by_range_reduction import lnrr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [IN_W-1:0]         in_probability,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_log_value,
  output logic                         out_is_neg_infinity
);

  localparam int SCL_W = 38;

  logic   en;
  stage_t p1 [0:N_PASS1];
  stage_t p2 [0:N_PASS2];
  stage_t p3 [0:N_PASS3];
  stage_t p4 [0:N_PASS4];

  tail_t t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  tail_t t4_r, t4_nxt, t5_r, t5_nxt, t6_r, t6_nxt;

  logic [MILLI_W-2:0] abs_m;
  logic [61:0]        d2_full, d3_full;
  logic [35:0]        mag;
  logic [SCL_W-1:0]   scaled;
  logic [OUT_W-1:0]   sat;

  logic                    out_valid_r, out_is_neg_infinity_r;
  logic                    out_valid_nxt, out_is_neg_infinity_nxt;
  logic signed [OUT_W-1:0] out_log_value_r, out_log_value_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    p1[0].valid = in_valid;
    p1[0].zero  = in_probability == '0;
    p1[0].x     = (in_probability == '0) ? ONE
                : (X_W'(in_probability) << (WORK_BITS - IN_FRAC));
    p1[0].milli = '0;
  end

  assign p2[0] = p1[N_PASS1];
  assign p3[0] = p2[N_PASS2];
  assign p4[0] = p3[N_PASS3];

  for (genvar i = 0; i < N_PASS1; i++) begin : g_pass1
    lnrr_mul_step #(.K(K_E1), .STEP(STEP_E1)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(p1[i]), .q_o(p1[i+1]));
  end
  for (genvar i = 0; i < N_PASS2; i++) begin : g_pass2
    lnrr_div_step #(.K(K_E01), .R(R_E01), .STEP(STEP_E01)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(p2[i]), .q_o(p2[i+1]));
  end
  for (genvar i = 0; i < N_PASS3; i++) begin : g_pass3
    lnrr_mul_step #(.K(K_E001), .STEP(STEP_E001)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(p3[i]), .q_o(p3[i+1]));
  end
  for (genvar i = 0; i < N_PASS4; i++) begin : g_pass4
    lnrr_div_step #(.K(K_E0001), .R(R_E0001), .STEP(STEP_E0001)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(p4[i]), .q_o(p4[i+1]));
  end

  always_comb begin
    abs_m          = p4[N_PASS4].milli[MILLI_W-1] ? (MILLI_W-1)'(-p4[N_PASS4].milli)
                                                  : p4[N_PASS4].milli[MILLI_W-2:0];
    t1_nxt         = '0;
    t1_nxt.valid   = p4[N_PASS4].valid;
    t1_nxt.zero    = p4[N_PASS4].zero;
    t1_nxt.neg     = p4[N_PASS4].milli[MILLI_W-1];
    t1_nxt.d       = 31'(ONE - p4[N_PASS4].x);
    t1_nxt.bulk_hi = 35'(abs_m) * 35'(BULK_INT);
    t1_nxt.v       = 24'(24'(abs_m) * 24'(BULK_REM) + 24'd500);
  end

  always_comb begin
    t2_nxt    = t1_r;
    d2_full   = 62'(t1_r.d) * 62'(t1_r.d);
    t2_nxt.d2 = d2_full[WORK_BITS +: 31];
    t2_nxt.tb = 43'(t1_r.v[23:3]) * 43'(DIV125_M);
  end

  always_comb begin
    t3_nxt      = t2_r;
    d3_full     = 62'(t2_r.d2) * 62'(t2_r.d);
    t3_nxt.d3   = d3_full[WORK_BITS +: 31];
    t3_nxt.bulk = t2_r.bulk_hi + 35'(t2_r.tb[42:DIV125_S]);
  end

  always_comb begin
    t4_nxt    = t3_r;
    t4_nxt.t3 = 64'(t3_r.d3) * 64'(DIV3_M);
  end

  always_comb begin
    t5_nxt   = t4_r;
    t5_nxt.r = 33'(t4_r.d) + 33'(t4_r.d2[30:1]) + 33'(t4_r.t3[63:33]);
  end

  always_comb begin
    t6_nxt       = t5_r;
    t6_nxt.total = (t5_r.neg ? -$signed({2'b00, t5_r.bulk}) : $signed({2'b00, t5_r.bulk}))
                 - $signed({4'b0000, t5_r.r});
  end

  assign mag = t6_r.total[36] ? 36'(-t6_r.total) : t6_r.total[35:0];

  if (FRAC_BITS >= WORK_BITS) begin : g_up
    assign scaled = {2'b00, mag} << (FRAC_BITS - WORK_BITS);
  end else begin : g_dn
    localparam int SH = WORK_BITS - FRAC_BITS;
    assign scaled = ({2'b00, mag} + (SCL_W'(1) << (SH - 1))) >> SH;
  end

  always_comb begin
    if (t6_r.total[36]) begin
      sat = (scaled > SCL_W'(1 << (OUT_W - 1))) ? OUT_W'(1 << (OUT_W - 1))
                                               : scaled[OUT_W-1:0];
      out_log_value_nxt = $signed(-sat);
    end else begin
      sat = (scaled > SCL_W'((1 << (OUT_W - 1)) - 1)) ? OUT_W'((1 << (OUT_W - 1)) - 1)
                                                     : scaled[OUT_W-1:0];
      out_log_value_nxt = $signed(sat);
    end
    if (t6_r.zero) begin
      out_log_value_nxt = '0;
    end
    out_valid_nxt           = t6_r.valid;
    out_is_neg_infinity_nxt = t6_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid  <= 1'b0;
      t2_r.valid  <= 1'b0;
      t3_r.valid  <= 1'b0;
      t4_r.valid  <= 1'b0;
      t5_r.valid  <= 1'b0;
      t6_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      t1_r                  <= t1_nxt;
      t2_r                  <= t2_nxt;
      t3_r                  <= t3_nxt;
      t4_r                  <= t4_nxt;
      t5_r                  <= t5_nxt;
      t6_r                  <= t6_nxt;
      out_valid_r           <= out_valid_nxt;
      out_log_value_r       <= out_log_value_nxt;
      out_is_neg_infinity_r <= out_is_neg_infinity_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_log_value       = out_log_value_r;
  assign out_is_neg_infinity = out_is_neg_infinity_r;

  `NLRR_ASSERT_IMP(a_neginf_zero, out_valid && out_is_neg_infinity, out_log_value == '0, "neg infinity result must carry zero log")
  `NLRR_ASSERT_IMP(a_pass1_done, p1[N_PASS1].valid, p1[N_PASS1].x >= ONE, "pass 1 ran out of steps")
  `NLRR_ASSERT_IMP(a_pass2_done, p2[N_PASS2].valid, p2[N_PASS2].x <= ONE, "pass 2 ran out of steps")
  `NLRR_ASSERT_IMP(a_pass3_done, p3[N_PASS3].valid, p3[N_PASS3].x >= ONE, "pass 3 ran out of steps")
  `NLRR_ASSERT_IMP(a_pass4_done, p4[N_PASS4].valid, p4[N_PASS4].x <= ONE, "pass 4 ran out of steps")
  `NLRR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready && t6_r.valid, t6_r.valid, "stage lost during stall")

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for natural_log_by_range_reduction: directed and random probabilities vs a log predictor.
`default_nettype none
module tb import lnrr_pkg::*;;

  localparam int FRAC_BITS = 16;
  localparam int N_RANDOM  = 1750;

  typedef struct packed {
    logic signed [OUT_W-1:0] log_value;
    logic                    is_neg_infinity;
  } log_result_t;

  function automatic log_result_t predict_log(logic [IN_W-1:0] prob);
    log_result_t res;
    logic [63:0] one, ke1, ke01, ke001, ke0001;
    logic [63:0] x, d, d2, d3, r, bmag, bq30, mag, half;
    longint signed milli, total;
    logic neg;
    one    = 64'd1 << WORK_BITS;
    ke1    = ((64'd2718281828 << WORK_BITS) + 64'd500000000) / 64'd1000000000;
    ke01   = ((64'd1105170918 << WORK_BITS) + 64'd500000000) / 64'd1000000000;
    ke001  = ((64'd1010050167 << WORK_BITS) + 64'd500000000) / 64'd1000000000;
    ke0001 = ((64'd1001000500 << WORK_BITS) + 64'd500000000) / 64'd1000000000;
    milli = 0;
    res = '0;
    if (prob == 0) begin
      res.is_neg_infinity = 1'b1;
      return res;
    end
    x = 64'(prob) << (WORK_BITS - IN_FRAC);
    while (x < one) begin
      x = (x * ke1) >> WORK_BITS;
      milli -= 1000;
    end
    while (x > one) begin
      x = (x << WORK_BITS) / ke01;
      milli += 100;
    end
    while (x < one) begin
      x = (x * ke001) >> WORK_BITS;
      milli -= 10;
    end
    while (x > one) begin
      x = (x << WORK_BITS) / ke0001;
      milli += 1;
    end
    d  = one - x;
    d2 = (d * d) >> WORK_BITS;
    d3 = (d2 * d) >> WORK_BITS;
    r  = d + d2 / 2 + d3 / 3;
    bmag = (milli < 0) ? 64'(-milli) : 64'(milli);
    bq30 = ((bmag << WORK_BITS) + 64'd500) / 64'd1000;
    total = ((milli < 0) ? -longint'(bq30) : longint'(bq30)) - longint'(r);
    neg = total < 0;
    mag = neg ? 64'(-total) : 64'(total);
    if (FRAC_BITS >= WORK_BITS) begin
      mag = mag << (FRAC_BITS - WORK_BITS);
    end else begin
      half = 64'd1 << (WORK_BITS - FRAC_BITS - 1);
      mag = (mag + half) >> (WORK_BITS - FRAC_BITS);
    end
    if (neg) begin
      if (mag > (64'd1 << (OUT_W - 1))) mag = 64'd1 << (OUT_W - 1);
      res.log_value = OUT_W'(~mag + 64'd1);
    end else begin
      if (mag > (64'd1 << (OUT_W - 1)) - 1) mag = (64'd1 << (OUT_W - 1)) - 1;
      res.log_value = OUT_W'(mag);
    end
    return res;
  endfunction

  class log_scoreboard;
    log_result_t pending_logs[$];
    int errors;

    function void note_probability(logic [IN_W-1:0] prob);
      pending_logs.push_back(predict_log(prob));
    endfunction

    function void check_log(logic signed [OUT_W-1:0] lv, logic ninf);
      log_result_t exp_r;
      if (pending_logs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result log=%0d ninf=%0b", lv, ninf);
        return;
      end
      exp_r = pending_logs.pop_front();
      if (exp_r.log_value !== lv || exp_r.is_neg_infinity !== ninf) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected log=%0d ninf=%0b, got log=%0d ninf=%0b",
                   exp_r.log_value, exp_r.is_neg_infinity, lv, ninf);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] in_probability = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_log_value;
  logic out_is_neg_infinity;
  log_scoreboard sb;
  int ready_hold = 0;

  always #5 clk = ~clk;

  natural_log_by_range_reduction #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_probability(in_probability),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_log_value(out_log_value),
    .out_is_neg_infinity(out_is_neg_infinity)
  );

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_probability(logic [IN_W-1:0] prob);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_probability <= prob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_probability(prob);
  endtask

  function automatic logic [IN_W-1:0] random_probability();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return IN_W'($urandom_range(1, 65536));
    if (sel < 7) return IN_W'($urandom_range(1, 255));
    if (sel < 8) return IN_W'($urandom_range(65000, 65536));
    if (sel < 9) return IN_W'($urandom_range(65537, 131071));
    return '0;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_log(out_log_value, out_is_neg_infinity);
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        out_ready  <= 1'b0;
      end else begin
        ready_hold <= pick_gap();
        out_ready  <= 1'b1;
      end
    end
  end

  initial begin
    logic [IN_W-1:0] directed[$];
    int waited;
    sb = new();
    directed = '{17'd0, 17'd1, 17'd2, 17'd3, 17'd255, 17'd256, 17'd4096, 17'd24109,
                 17'd32768, 17'd65535, 17'd65536, 17'd65537, 17'd98304, 17'd131071,
                 17'h15555, 17'h0AAAA, 17'h1FFFE, 17'd60000, 17'd1000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_probability(directed[i]);
    repeat (N_RANDOM) send_probability(random_probability());
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_logs.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_logs.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
